### hw/rtl/tiel_pkg.sv
// Shared types, codes and decode helpers for the TIFF directory entry locator.
package tiel_pkg;

	localparam int POSITION_BITS = 32;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	localparam logic [15:0] ORDER_II     = 16'h4949;
	localparam logic [15:0] ORDER_MM     = 16'h4d4d;
	localparam logic [15:0] TIFF_MAGIC   = 16'd42;
	localparam logic [15:0] MAX_NO_MATCH = 16'd253;
	localparam logic [31:0] HEADER_BYTES = 32'd8;
	localparam logic [3:0]  ENTRY_BYTES  = 4'd12;

	typedef enum logic [2:0] {
		ST_INLINE   = 3'd0,
		ST_OFFSET   = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_BADORDER = 3'd3,
		ST_BADMAGIC = 3'd4,
		ST_BACKWARD = 3'd5,
		ST_BADTYPE  = 3'd6
	} status_t;

	typedef enum logic [7:0] {
		PH_IDLE   = 8'b0000_0001,
		PH_ORDER  = 8'b0000_0010,
		PH_MAGIC  = 8'b0000_0100,
		PH_OFFSET = 8'b0000_1000,
		PH_SKIP   = 8'b0001_0000,
		PH_COUNT  = 8'b0010_0000,
		PH_ENTRY  = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [31:0] raw_field;
		logic [15:0] second_short;
		logic [15:0] first_short;
		logic [31:0] word_value;
		logic [31:0] value_count;
		logic [15:0] field_type;
		logic [2:0]  status;
	} result_t;

	function automatic logic [15:0] dec16(input logic be, input logic [7:0] first,
		input logic [7:0] second);
		return be ? {first, second} : {second, first};
	endfunction

	function automatic logic [31:0] dec32(input logic be, input logic [31:0] raw);
		return be ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
	endfunction

	function automatic status_t classify(input logic [15:0] ftype, input logic [31:0] count);
		status_t st;
		case (ftype)
			16'd1, 16'd2, 16'd6, 16'd7: st = (count > 32'd4) ? ST_OFFSET : ST_INLINE;
			16'd3, 16'd8:               st = (count > 32'd2) ? ST_OFFSET : ST_INLINE;
			16'd4, 16'd9:               st = (count > 32'd1) ? ST_OFFSET : ST_INLINE;
			16'd5, 16'd10, 16'd11, 16'd12, 16'd13, 16'd16, 16'd17, 16'd18: st = ST_OFFSET;
			default:                    st = ST_BADTYPE;
		endcase
		return st;
	endfunction

endpackage

### hw/rtl/tiff_ifd_entry_locator.sv
// Top level: TIFF header check and first-directory entry locator on a byte stream.
// One file byte per item, one item per cycle unless a result waits at the output. An
// item is registered at the input, then parsed from that register by counters, compares
// and byte shuffles, and a result goes to an output register. The input stage advances
// when the output register is empty or taken in that cycle, so a result left waiting at
// the output holds further bytes. A byte with tuser set restarts the parse.
module tiff_ifd_entry_locator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,     // wanted_tag
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,       // file_byte
	input  logic         s_tuser,       // start_of_file
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata        // status, field_type, value_count, word_value,
	                                    // first_short, second_short, raw_field, 5'b0
);
	import tiel_pkg::*;

	logic [15:0] wanted_tag_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        sof_s1;

	phase_t                   phase_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     be_q;
	logic [31:0]              gather_q;
	logic [31:0]              dir_off_q;
	logic [15:0]              entries_q;
	logic [3:0]               idx_q;
	logic [7:0]               entry_q [12];

	logic    out_valid_q;
	result_t result_q;

	logic advance;
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	phase_t                   phase_e, phase_d;
	logic [POSITION_BITS-1:0] pos_e;
	logic [31:0]              pos_w;
	logic [31:0]              gather_e, gather_d, gather_or;
	logic [3:0]               idx_e, idx_d;
	logic                     be_d;
	logic [31:0]              dir_off_d;
	logic [15:0]              entries_d, entries_dec;
	logic                     wr_entry;
	logic [3:0]               wr_idx;
	logic                     produce;
	result_t                  result_d;
	logic [15:0]              tag, ftype, order_word;
	logic [31:0]              count, raw;
	status_t                  cls;

	always_comb begin
		phase_e  = sof_s1 ? PH_ORDER : phase_q;
		pos_e    = sof_s1 ? '0 : pos_q;
		gather_e = sof_s1 ? '0 : gather_q;
		idx_e    = sof_s1 ? '0 : idx_q;
		pos_w    = 32'(pos_e);

		gather_or   = gather_e | (32'(byte_s1) << {pos_e[1:0], 3'b000});
		order_word  = {gather_e[7:0], byte_s1};
		entries_dec = entries_q - 16'd1;

		tag   = dec16(be_q, entry_q[0], entry_q[1]);
		ftype = dec16(be_q, entry_q[2], entry_q[3]);
		count = dec32(be_q, {entry_q[7], entry_q[6], entry_q[5], entry_q[4]});
		raw   = {byte_s1, entry_q[10], entry_q[9], entry_q[8]};
		cls   = classify(ftype, count);

		phase_d   = phase_e;
		gather_d  = gather_e;
		idx_d     = idx_e;
		be_d      = be_q;
		dir_off_d = dir_off_q;
		entries_d = entries_q;
		wr_entry  = 1'b0;
		wr_idx    = idx_e;
		produce   = 1'b0;
		result_d  = '0;

		case (phase_e)
			PH_IDLE, PH_DONE: begin
			end
			PH_ORDER: begin
				if (pos_e == '0) begin
					gather_d = 32'(byte_s1);
				end else if (order_word == ORDER_II || order_word == ORDER_MM) begin
					be_d    = (order_word == ORDER_MM);
					phase_d = PH_MAGIC;
				end else begin
					produce         = 1'b1;
					result_d.status = ST_BADORDER;
				end
			end
			PH_MAGIC: begin
				if (pos_w == 32'd2) begin
					gather_d = 32'(byte_s1);
				end else if (dec16(be_q, gather_e[7:0], byte_s1) == TIFF_MAGIC) begin
					phase_d  = PH_OFFSET;
					gather_d = '0;
				end else begin
					produce         = 1'b1;
					result_d.status = ST_BADMAGIC;
				end
			end
			PH_OFFSET: begin
				gather_d = gather_or;
				if (pos_e[1:0] == 2'd3) begin
					dir_off_d = dec32(be_q, gather_or);
					if (dir_off_d < HEADER_BYTES) begin
						produce         = 1'b1;
						result_d.status = ST_BACKWARD;
					end else begin
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (pos_w == dir_off_q) begin
					wr_entry = 1'b1;
					wr_idx   = '0;
					idx_d    = 4'd1;
					phase_d  = PH_COUNT;
				end
			end
			PH_COUNT: begin
				entries_d = dec16(be_q, entry_q[0], byte_s1);
				idx_d     = '0;
				if (entries_d == '0) begin
					produce         = 1'b1;
					result_d.status = ST_NOTFOUND;
				end else begin
					phase_d = PH_ENTRY;
				end
			end
			PH_ENTRY: begin
				wr_entry = 1'b1;
				idx_d    = idx_e + 4'd1;
				if (idx_d >= ENTRY_BYTES) begin
					idx_d = '0;
					if (tag > MAX_NO_MATCH && tag == wanted_tag_q) begin
						produce               = 1'b1;
						result_d.status       = cls;
						result_d.field_type   = ftype;
						result_d.value_count  = count;
						result_d.word_value   = dec32(be_q, raw);
						result_d.raw_field    = raw;
						if (cls == ST_INLINE && (ftype == 16'd3 || ftype == 16'd8)) begin
							result_d.first_short  = dec16(be_q, raw[7:0], raw[15:8]);
							result_d.second_short = dec16(be_q, raw[23:16], raw[31:24]);
						end
					end else begin
						entries_d = entries_dec;
						if (entries_dec == '0) begin
							produce         = 1'b1;
							result_d.status = ST_NOTFOUND;
						end
					end
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
		if (produce) begin
			phase_d = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_tag_q <= 16'd256;
		end else if (cfg_we) begin
			wanted_tag_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			sof_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= '0;
			be_q      <= 1'b0;
			gather_q  <= '0;
			dir_off_q <= '0;
			entries_q <= '0;
			idx_q     <= '0;
		end else if (advance && (sof_s1 || (phase_q != PH_IDLE && phase_q != PH_DONE))) begin
			phase_q   <= phase_d;
			pos_q     <= (pos_e < POS_MAX) ? pos_e + 1'b1 : pos_e;
			be_q      <= be_d;
			gather_q  <= gather_d;
			dir_off_q <= dir_off_d;
			entries_q <= entries_d;
			idx_q     <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_entry) begin
			entry_q[wr_idx] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, result_q};

	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && produce |=> phase_q == PH_DONE)
		else $error("parse not finished after a result");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> result_q.status <= ST_BADTYPE)
		else $error("status code out of range");

	a_error_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.status != ST_INLINE && result_q.status != ST_OFFSET
		&& result_q.status != ST_BADTYPE |-> result_q.field_type == '0
		&& result_q.value_count == '0 && result_q.raw_field == '0)
		else $error("error result carries entry fields");

	a_shorts_inline_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.status != ST_INLINE |->
		result_q.first_short == '0 && result_q.second_short == '0)
		else $error("short values outside an inline result");

endmodule

### tb/ifd_result_check.sv
// Result checker for the TIFF directory entry locator: predicts from the accepted byte stream and compares.
module ifd_result_check (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [151:0] m_tdata,
	output int           errors,
	output int           pending,
	output int           results
);
	timeunit 1ns;
	timeprecision 1ps;

	import tiel_pkg::*;

	localparam logic [15:0] TY_BYTE      = 16'd1;
	localparam logic [15:0] TY_ASCII     = 16'd2;
	localparam logic [15:0] TY_SHORT     = 16'd3;
	localparam logic [15:0] TY_LONG      = 16'd4;
	localparam logic [15:0] TY_RATIONAL  = 16'd5;
	localparam logic [15:0] TY_SBYTE     = 16'd6;
	localparam logic [15:0] TY_UNDEFINED = 16'd7;
	localparam logic [15:0] TY_SSHORT    = 16'd8;
	localparam logic [15:0] TY_SLONG     = 16'd9;
	localparam logic [15:0] TY_SRATIONAL = 16'd10;
	localparam logic [15:0] TY_FLOAT     = 16'd11;
	localparam logic [15:0] TY_DOUBLE    = 16'd12;
	localparam logic [15:0] TY_IFD       = 16'd13;
	localparam logic [15:0] TY_LONG8     = 16'd16;
	localparam logic [15:0] TY_SLONG8    = 16'd17;
	localparam logic [15:0] TY_IFD8      = 16'd18;
	localparam logic [15:0] TAG_AT_RESET = 16'd256;

	phase_t      phase;
	logic [31:0] pos;
	logic [31:0] gather;
	logic [31:0] dir_off;
	logic        big;
	logic [15:0] left;
	logic [15:0] tag_sel;
	logic [7:0]  ent [12];
	logic [3:0]  ent_idx;
	result_t     due_results [$];
	int          mismatches;
	int          seen;

	function automatic logic [15:0] order16(input logic [7:0] first, input logic [7:0] second);
		return big ? {first, second} : {second, first};
	endfunction

	// raw holds four file bytes, first byte in the low bits
	function automatic logic [31:0] order32(input logic [31:0] raw);
		return big ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
	endfunction

	task automatic emit_status(input status_t st);
		result_t r;
		r = '0;
		r.status = st;
		due_results.push_back(r);
		phase = PH_DONE;
	endtask

	task automatic emit_entry();
		result_t     r;
		logic [15:0] ft;
		logic [31:0] cnt;
		logic [31:0] raw;
		ft = order16(ent[2], ent[3]);
		cnt = order32({ent[7], ent[6], ent[5], ent[4]});
		raw = {ent[11], ent[10], ent[9], ent[8]};
		r = '0;
		r.field_type = ft;
		r.value_count = cnt;
		r.word_value = order32(raw);
		r.raw_field = raw;
		case (ft)
			TY_BYTE, TY_ASCII, TY_SBYTE, TY_UNDEFINED: begin
				r.status = (cnt > 32'd4) ? ST_OFFSET : ST_INLINE;
			end
			TY_SHORT, TY_SSHORT: begin
				r.status = (cnt > 32'd2) ? ST_OFFSET : ST_INLINE;
				if (r.status == ST_INLINE) begin
					r.first_short = order16(ent[8], ent[9]);
					r.second_short = order16(ent[10], ent[11]);
				end
			end
			TY_LONG, TY_SLONG: begin
				r.status = (cnt > 32'd1) ? ST_OFFSET : ST_INLINE;
			end
			TY_RATIONAL, TY_SRATIONAL, TY_FLOAT, TY_DOUBLE, TY_IFD, TY_LONG8, TY_SLONG8,
			TY_IFD8: begin
				r.status = ST_OFFSET;
			end
			default: begin
				r.status = ST_BADTYPE;
			end
		endcase
		due_results.push_back(r);
		phase = PH_DONE;
	endtask

	task automatic parse_file_byte(input logic [7:0] b, input logic sof);
		logic [31:0] at;
		logic [1:0]  k;
		logic [15:0] tag;
		if (sof) begin
			phase = PH_ORDER;
			pos = '0;
			gather = '0;
			ent_idx = '0;
		end
		if (phase == PH_IDLE || phase == PH_DONE)
			return;
		at = pos;
		if (pos != POS_MAX)
			pos = pos + 32'd1;
		case (phase)
			PH_ORDER: begin
				if (at == 32'd0) begin
					gather = {24'd0, b};
				end else if (gather[7:0] == b && (b == ORDER_II[7:0] || b == ORDER_MM[7:0])) begin
					big = (b == ORDER_MM[7:0]);
					phase = PH_MAGIC;
				end else begin
					emit_status(ST_BADORDER);
				end
			end
			PH_MAGIC: begin
				if (at == 32'd2) begin
					gather = {24'd0, b};
				end else if (order16(gather[7:0], b) == TIFF_MAGIC) begin
					phase = PH_OFFSET;
					gather = '0;
				end else begin
					emit_status(ST_BADMAGIC);
				end
			end
			PH_OFFSET: begin
				k = at[1:0];
				gather = gather | ({24'd0, b} << (8 * k));
				if (k == 2'd3) begin
					dir_off = order32(gather);
					if (dir_off < HEADER_BYTES)
						emit_status(ST_BACKWARD);
					else
						phase = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (at == dir_off) begin
					ent[0] = b;
					ent_idx = 4'd1;
					phase = PH_COUNT;
				end
			end
			PH_COUNT: begin
				left = order16(ent[0], b);
				ent_idx = '0;
				if (left == 16'd0)
					emit_status(ST_NOTFOUND);
				else
					phase = PH_ENTRY;
			end
			PH_ENTRY: begin
				ent[ent_idx] = b;
				ent_idx = ent_idx + 4'd1;
				if (ent_idx >= ENTRY_BYTES) begin
					tag = order16(ent[0], ent[1]);
					ent_idx = '0;
					if (tag > MAX_NO_MATCH && tag == tag_sel) begin
						emit_entry();
					end else begin
						left = left - 16'd1;
						if (left == 16'd0)
							emit_status(ST_NOTFOUND);
					end
				end
			end
			default: begin
				phase = PH_DONE;
			end
		endcase
	endtask

	task automatic compare_result(input result_t want);
		result_t got;
		got = m_tdata[146:0];
		if (got.status != want.status || got.field_type != want.field_type ||
				got.value_count != want.value_count || got.word_value != want.word_value ||
				got.first_short != want.first_short || got.second_short != want.second_short ||
				got.raw_field != want.raw_field || m_tdata[151:147] != 5'd0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: mismatch on result %0d", $realtime, seen);
				$display("  expected status %0d type %h count %h word %h shorts %h %h raw %h",
					want.status, want.field_type, want.value_count, want.word_value,
					want.first_short, want.second_short, want.raw_field);
				$display("  actual   status %0d type %h count %h word %h shorts %h %h raw %h pad %h",
					got.status, got.field_type, got.value_count, got.word_value,
					got.first_short, got.second_short, got.raw_field, m_tdata[151:147]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_IDLE;
			pos = '0;
			gather = '0;
			dir_off = '0;
			big = 1'b0;
			left = '0;
			ent_idx = '0;
			tag_sel = TAG_AT_RESET;
			for (int i = 0; i < 12; i++)
				ent[i] = '0;
			due_results.delete();
			mismatches = 0;
			seen = 0;
			errors <= 0;
			pending <= 0;
			results <= 0;
		end else begin
			if (cfg_we)
				tag_sel = cfg_wdata;
			if (s_tvalid && s_tready)
				parse_file_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none expected, status %0d", $realtime,
							m_tdata[2:0]);
				end else begin
					compare_result(due_results.pop_front());
				end
				seen++;
			end
			errors <= mismatches;
			pending <= due_results.size();
			results <= seen;
		end
	end

endmodule

### tb/tb.sv
// Testbench top for the TIFF directory entry locator: clock, reset, file stimulus and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tiel_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD   = 200;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [15:0]  cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [151:0] m_tdata;

	int errors;
	int pending;
	int results;

	int          cycles = 0;
	int          tx_idle = 37;
	int          rx_idle = 51;
	int          hold_token = 0;
	int          hold_served = 0;
	int          sent = 0;
	int          files = 0;
	int          tag_writes = 0;
	logic [15:0] cur_tag = 16'd256;
	logic [7:0]  img [$];
	logic        img_big;

	tiff_ifd_entry_locator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ifd_result_check result_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending),
		.results  (results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_token != hold_served) begin
			hold_served = hold_token;
			m_tready <= 1'b0;
			repeat (LONG_HOLD) @(posedge clk);
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic sof);
		while (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= sof;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_file();
		int i;
		for (i = 0; i < img.size(); i++)
			send_item(img[i], i == 0);
		files++;
	endtask

	// drop valid and wait until the block has nothing left in flight
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_tag(input logic [15:0] tag);
		settle();
		cfg_wdata <= tag;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_tag = tag;
		tag_writes++;
	endtask

	task automatic put8(input logic [7:0] b);
		img.push_back(b);
	endtask

	task automatic put16(input logic [15:0] v);
		if (img_big) begin
			put8(v[15:8]);
			put8(v[7:0]);
		end else begin
			put8(v[7:0]);
			put8(v[15:8]);
		end
	endtask

	task automatic put32(input logic [31:0] v);
		if (img_big) begin
			put16(v[31:16]);
			put16(v[15:0]);
		end else begin
			put16(v[15:0]);
			put16(v[31:16]);
		end
	endtask

	task automatic add_noise(input int n);
		repeat (n) put8(8'($urandom));
	endtask

	// hit is the index of the entry carrying the wanted tag, -1 for none
	task automatic build_tiff(input logic big, input logic [31:0] dir, input int n_ent,
		input logic [15:0] n_field, input int hit, input logic [15:0] ftype,
		input logic [31:0] fcount);
		int          i;
		logic [15:0] tag;
		img.delete();
		img_big = big;
		put8(big ? ORDER_MM[7:0] : ORDER_II[7:0]);
		put8(big ? ORDER_MM[7:0] : ORDER_II[7:0]);
		put16(TIFF_MAGIC);
		put32(dir);
		if (dir < HEADER_BYTES)
			return;
		while (img.size() < dir && img.size() < 320)
			put8(8'($urandom));
		put16(n_field);
		for (i = 0; i < n_ent; i++) begin
			if (i == hit) begin
				put16(cur_tag);
				put16(ftype);
				put32(fcount);
			end else begin
				tag = 16'($urandom);
				if (tag == cur_tag)
					tag = tag ^ 16'h8000;
				put16(tag);
				put16(16'($urandom_range(19)));
				put32($urandom_range(8));
			end
			put32($urandom);
		end
	endtask

	task automatic build_bad_order();
		logic [7:0] b0;
		logic [7:0] b1;
		b0 = ($urandom_range(1) == 0) ? ORDER_II[7:0] : 8'($urandom);
		b1 = ($urandom_range(1) == 0) ? b0 : 8'($urandom);
		if (b0 == b1 && (b0 == ORDER_II[7:0] || b0 == ORDER_MM[7:0]))
			b1 = b1 ^ 8'h04;
		img.delete();
		put8(b0);
		put8(b1);
	endtask

	task automatic build_bad_magic();
		logic [15:0] magic;
		img.delete();
		img_big = 1'($urandom_range(1));
		put8(img_big ? ORDER_MM[7:0] : ORDER_II[7:0]);
		put8(img_big ? ORDER_MM[7:0] : ORDER_II[7:0]);
		magic = 16'($urandom);
		if (magic == TIFF_MAGIC)
			magic = magic ^ 16'h0100;
		put16(magic);
	endtask

	function automatic logic [15:0] pick_tag();
		return 16'(($urandom_range(7) == 0) ? $urandom_range(253) : $urandom_range(65535, 254));
	endfunction

	task automatic random_file();
		int          pick;
		int          n;
		int          hit;
		int          gap;
		int          cut;
		logic [15:0] ftype;
		logic [31:0] fcount;
		if ($urandom_range(7) == 0)
			set_tag(pick_tag());
		pick = $urandom_range(99);
		ftype = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(19));
		fcount = ($urandom_range(4) == 0) ? $urandom : $urandom_range(6);
		if (pick < 6) begin
			build_bad_order();
		end else if (pick < 11) begin
			build_bad_magic();
		end else if (pick < 15) begin
			build_tiff(1'($urandom_range(1)), $urandom_range(7), 0, 16'd0, -1, ftype, fcount);
		end else begin
			gap = ($urandom_range(19) == 0) ? $urandom_range(300, 100) : $urandom_range(12);
			n = $urandom_range(4, 1);
			hit = ($urandom_range(3) == 0) ? -1 : $urandom_range(n - 1);
			build_tiff(1'($urandom_range(1)), HEADER_BYTES + gap, n,
				(pick < 19) ? 16'd0 : n[15:0], hit, ftype, fcount);
			if (pick >= 19 && pick < 25) begin
				cut = $urandom_range(img.size() - 1, 1);
				img = img[0:cut-1];
			end
		end
		add_noise($urandom_range(3));
		send_file();
	endtask

	initial begin
		int t;
		int seg;
		int seg_items;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		repeat (3) send_item(8'($urandom), 1'b0);

		for (t = 0; t < 4; t++) begin
			build_tiff(t[0], HEADER_BYTES + t, 1, 16'd1, 0, t[15:0], (t * 5) % 7);
			send_file();
		end
		build_tiff(1'b1, HEADER_BYTES, 2, 16'd2, 1, 16'hFFFF, 32'hFFFF_FFFF);
		send_file();
		build_tiff(1'b0, HEADER_BYTES, 3, 16'd3, -1, 16'd0, 32'd0);
		send_file();
		build_tiff(1'b1, HEADER_BYTES + 2, 2, 16'd0, 0, 16'd0, 32'd0);
		send_file();

		img.delete();
		put8(ORDER_II[7:0]);
		put8(ORDER_MM[7:0]);
		send_file();
		img.delete();
		img_big = 1'b0;
		put8(ORDER_II[7:0]);
		put8(ORDER_II[7:0]);
		put16(16'h2A00);
		send_file();
		build_tiff(1'b0, HEADER_BYTES - 1, 0, 16'd0, -1, 16'd0, 32'd0);
		add_noise(3);
		send_file();
		build_tiff(1'b1, 32'd0, 0, 16'd0, -1, 16'd0, 32'd0);
		send_file();

		build_tiff(1'b0, 32'hFFFF_FFFF, 0, 16'd0, -1, 16'd0, 32'd0);
		img = img[0:23];
		send_file();

		set_tag(16'hFFFF);
		build_tiff(1'b0, HEADER_BYTES, 2, 16'd2, 1, 16'd3, 32'd1);
		send_file();
		set_tag(16'd0);
		build_tiff(1'b1, HEADER_BYTES, 2, 16'd2, 0, 16'd4, 32'd1);
		send_file();
		set_tag(MAX_NO_MATCH);
		build_tiff(1'b0, HEADER_BYTES, 1, 16'd1, 0, 16'd1, 32'd4);
		send_file();
		set_tag(MAX_NO_MATCH + 16'd1);
		build_tiff(1'b1, HEADER_BYTES, 1, 16'd1, 0, 16'd8, 32'd2);
		send_file();

		hold_token <= hold_token + 1;
		repeat (12) begin
			build_bad_order();
			send_file();
		end
		settle();

		for (seg = 0; seg < 3; seg++) begin
			tx_idle = (seg == 0) ? 37 : (seg == 1) ? 51 : 0;
			rx_idle <= (seg == 0) ? 51 : (seg == 1) ? 37 : 0;
			seg_items = sent;
			while (sent - seg_items < 36)
				random_file();
		end

		settle();
		$display("Covered %0d files in %0d bytes with %0d tag writes; %0d results checked",
			files, sent, tag_writes, results);
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
hw/rtl/tiel_pkg.sv
hw/rtl/tiff_ifd_entry_locator.sv
tb/ifd_result_check.sv
tb/tb.sv
